>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int IdxW     = 10;
    localparam int DataW    = 32;
    localparam int CtrlW    = 9;
    localparam int StatW    = 7;
    localparam int ByteW    = 8;
    localparam int AddrW    = 7;
    localparam int InDataW  = 56;
    localparam int OutDataW = 56;

    localparam logic [IdxW-1:0] REG_CONTROL  = 10'd0;
    localparam logic [IdxW-1:0] REG_COMMAND  = 10'd1;
    localparam logic [IdxW-1:0] REG_CLEAR    = 10'd2;
    localparam logic [IdxW-1:0] REG_STATUS   = 10'd3;
    localparam logic [IdxW-1:0] REG_CLK_HIGH = 10'd4;
    localparam logic [IdxW-1:0] REG_CLK_LOW  = 10'd5;
    localparam logic [IdxW-1:0] REG_TRANSMIT = 10'd6;
    localparam logic [IdxW-1:0] REG_RECEIVE  = 10'd7;

    // command register bit positions
    localparam int CMD_STOP  = 0;
    localparam int CMD_WRITE = 1;
    localparam int CMD_READ  = 2;
    localparam int CMD_START = 3;

    localparam logic ACCESS_READ  = 1'b0;
    localparam logic ACCESS_WRITE = 1'b1;

    // status bit positions
    localparam int ST_OVER    = 0;
    localparam int ST_NACK    = 2;
    localparam int ST_RECEIVE = 3;
    localparam int ST_SEND    = 4;
    localparam int ST_END     = 5;
    localparam int ST_START   = 6;

    typedef struct packed {
        logic             command;
        logic [ByteW-1:0] bus_rx_data;
        logic             slave_acked;
        logic [DataW-1:0] write_data;
        logic [IdxW-1:0]  register_index;
    } item_t;

    typedef struct packed {
        logic             end_issued;
        logic             receive_issued;
        logic [ByteW-1:0] send_byte;
        logic             send_issued;
        logic             start_is_read;
        logic [AddrW-1:0] start_address;
        logic             start_issued;
        logic             end_before_start;
        logic [DataW-1:0] read_data;
    } result_t;

    localparam int ResultW = $bits(result_t);

endpackage

`default_nettype wire

>>> rtl/i2cm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire i2cm_pkg::item_t item,
    output i2cm_pkg::result_t    result
);
    import i2cm_pkg::*;

    logic [CtrlW-1:0] control_reg,   control_next;
    logic [StatW-1:0] status_reg,    status_next;
    logic [DataW-1:0] clk_high_reg,  clk_high_next;
    logic [DataW-1:0] clk_low_reg,   clk_low_next;
    logic [ByteW-1:0] transmit_reg,  transmit_next;
    logic [ByteW-1:0] receive_reg,   receive_next;
    logic             open_reg,      open_next;
    logic             reads_reg,     reads_next;

    logic             is_cmd;
    logic             do_start, do_write, do_read, do_stop;
    logic             open_mid, reads_mid;
    logic             send_go, recv_go, end_go;
    logic [StatW-1:0] cmd_status;

    always_comb
    begin
        is_cmd   = (item.command == ACCESS_WRITE) && (item.register_index == REG_COMMAND);
        do_start = is_cmd && item.write_data[CMD_START];
        do_write = is_cmd && item.write_data[CMD_WRITE];
        do_read  = is_cmd && item.write_data[CMD_READ];
        do_stop  = is_cmd && item.write_data[CMD_STOP];

        // start closes any open transfer, then opens one if the slave answers
        open_mid  = do_start ? item.slave_acked : open_reg;
        reads_mid = (do_start && item.slave_acked) ? transmit_reg[0] : reads_reg;

        send_go = do_write && !do_start && open_mid && !reads_mid;
        recv_go = do_read && open_mid && reads_mid;
        end_go  = do_stop && open_mid;

        cmd_status = status_reg;
        cmd_status[ST_START]   = cmd_status[ST_START] | (do_start && item.slave_acked);
        cmd_status[ST_NACK]    = cmd_status[ST_NACK] | (do_start && !item.slave_acked);
        cmd_status[ST_SEND]    = cmd_status[ST_SEND] | send_go;
        cmd_status[ST_RECEIVE] = cmd_status[ST_RECEIVE] | recv_go;
        cmd_status[ST_END]     = cmd_status[ST_END] | do_stop;
        cmd_status[ST_OVER]    = 1'b1;

        control_next  = control_reg;
        status_next   = status_reg;
        clk_high_next = clk_high_reg;
        clk_low_next  = clk_low_reg;
        transmit_next = transmit_reg;
        receive_next  = recv_go ? item.bus_rx_data : receive_reg;
        open_next     = do_stop ? 1'b0 : open_mid;
        reads_next    = reads_mid;

        if (item.command == ACCESS_WRITE)
        begin
            case (item.register_index)
                REG_CONTROL:  control_next  = item.write_data[CtrlW-1:0];
                REG_COMMAND:  status_next   = cmd_status;
                REG_CLEAR:    status_next   = status_reg & ~item.write_data[StatW-1:0];
                REG_CLK_HIGH: clk_high_next = item.write_data;
                REG_CLK_LOW:  clk_low_next  = item.write_data;
                REG_TRANSMIT: transmit_next = item.write_data[ByteW-1:0];
                default:      ;
            endcase
        end

        result                  = '0;
        result.end_before_start = do_start && open_reg;
        result.start_issued     = do_start;
        result.start_address    = do_start ? transmit_reg[ByteW-1:1] : '0;
        result.start_is_read    = do_start && transmit_reg[0];
        result.send_issued      = send_go;
        result.send_byte        = send_go ? transmit_reg : '0;
        result.receive_issued   = recv_go;
        result.end_issued       = end_go;

        if (item.command == ACCESS_READ)
        begin
            case (item.register_index)
                REG_CONTROL:  result.read_data = {{(DataW-CtrlW){1'b0}}, control_reg};
                REG_STATUS:   result.read_data = {{(DataW-StatW){1'b0}}, status_reg};
                REG_CLK_HIGH: result.read_data = clk_high_reg;
                REG_CLK_LOW:  result.read_data = clk_low_reg;
                REG_TRANSMIT: result.read_data = {{(DataW-ByteW){1'b0}}, transmit_reg};
                REG_RECEIVE:  result.read_data = {{(DataW-ByteW){1'b0}}, receive_reg};
                default:      result.read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            status_reg   <= '0;
            clk_high_reg <= '0;
            clk_low_reg  <= '0;
            transmit_reg <= '0;
            receive_reg  <= '0;
            open_reg     <= 1'b0;
            reads_reg    <= 1'b0;
        end
        else if (en)
        begin
            control_reg  <= control_next;
            status_reg   <= status_next;
            clk_high_reg <= clk_high_next;
            clk_low_reg  <= clk_low_next;
            transmit_reg <= transmit_next;
            receive_reg  <= receive_next;
            open_reg     <= open_next;
            reads_reg    <= reads_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2c_master_register_block.sv
`timescale 1ns / 1ps
`default_nettype none

// Register front end of a polled I2C master.
// Slave side (s_*): one register access per transaction. s_tuser is the access
// kind (0 read, 1 write); s_tdata carries index, write data and the bus response
// for that access (acked flag and receive byte).
// Master side (m_*): exactly one result per access, in order: read data plus
// the bus operations that a command write decoded (end, start, send, receive).
// A transaction passes two registers in order: the input register, then the
// result register. Throughput: one access per cycle while the result register
// is free or m_tready is high, set by the combinational decode and state update
// between the two registers. While a result waits, the input register still
// takes a transaction if it is empty; when m_tready stays low both registers
// fill and s_tready drops, nothing is lost or repeated.
// Reset clears all registers (control, clock periods, transmit, receive,
// status, transfer state) and empties both pipeline registers.
module i2c_master_register_block (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // register_index[9:0], write_data[41:10], slave_acked[42], bus_rx_data[50:43]
    input  wire logic [i2cm_pkg::InDataW-1:0]  s_tdata,
    // command[0]
    input  wire logic                          s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // read_data[31:0], end_before_start[32], start_issued[33], start_address[40:34],
    // start_is_read[41], send_issued[42], send_byte[50:43], receive_issued[51],
    // end_issued[52]
    output      logic [i2cm_pkg::OutDataW-1:0] m_tdata
);
    import i2cm_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-ResultW){1'b0}}, out_result_reg};

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    i2cm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (in_valid_reg && advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= {s_tuser, s_tdata[$bits(item_t)-2:0]};
        end
        if (in_valid_reg && advance)
        begin
            out_result_reg <= core_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2cm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [i2cm_pkg::InDataW-1:0]  s_tdata,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [i2cm_pkg::OutDataW-1:0] m_tdata
);
    import i2cm_pkg::*;

    // start fields are zero unless a start went out
    a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[33]) |-> (m_tdata[41:34] == 8'd0 && !m_tdata[32]))
        else $error("start fields set without start");

    a_send_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[42]) |-> (m_tdata[50:43] == 8'd0))
        else $error("send byte set without send");

    // a transfer has one direction
    a_send_recv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[42] && m_tdata[51]))
        else $error("send and receive in one transaction");

    // a read access never drives the bus
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:0] == 32'd0 || m_tdata[52:32] == 21'd0))
        else $error("read data together with bus operation");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind i2c_master_register_block i2cm_checker u_checker (.*);

`default_nettype wire
